FILE: sv/pse_pkg.sv
// pse_pkg: shared widths, codes and types of the prime sieve engine
// no dependencies; imported by pse_mod_unit and prime_sieve_engine_top
package pse_pkg;

  localparam int NUM_W              = 16;  // width of a number field
  localparam int TRIAL_W            = 8;   // width of a trial base
  localparam int OP_W               = 2;
  localparam int APB_W              = 32;
  localparam int APB_ADDR_W         = 2;
  localparam int MAX_NUMBER_DEFAULT = 65535;
  localparam int MIN_BASE           = 2;

  localparam logic [APB_ADDR_W-1:0] TRIAL_LIMIT_ADDR = '0;

  localparam logic [TRIAL_W-1:0] TRIAL_LIMIT_RESET = 8'd255;

  localparam logic [OP_W-1:0] OP_SIEVE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  // request to the bit-serial remainder unit
  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;
    logic [TRIAL_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [TRIAL_W-1:0] rem;
  } mod_rsp_t;

endpackage

FILE: sv/pse_mod_unit.sv
// pse_mod_unit: restoring remainder unit, one dividend bit per cycle
// depends on pse_pkg (widths, request and response structs)
module pse_mod_unit (
  input  logic           clk,
  input  logic           rst,
  input  pse_pkg::mod_req_t req,
  output pse_pkg::mod_rsp_t rsp
);
  import pse_pkg::*;

  localparam int CntW = $clog2(NUM_W + 1);

  logic [CntW-1:0]    cnt;
  logic [NUM_W-1:0]   dvd;
  logic [TRIAL_W-1:0] dsr;
  logic [TRIAL_W-1:0] rem;
  logic               done;
  logic [TRIAL_W:0]   trial;
  logic [TRIAL_W:0]   diff;

  assign trial = {rem, dvd[NUM_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CntW'(NUM_W);
        dvd <= req.dividend;
        dsr <= req.divisor;
        rem <= '0;
      end else if (cnt != '0) begin
        cnt <= cnt - CntW'(1);
        dvd <= dvd << 1;
        // partial remainder stays below the divisor, so the difference fits
        rem <= (trial >= {1'b0, dsr}) ? diff[TRIAL_W-1:0] : trial[TRIAL_W-1:0];
        done <= (cnt == CntW'(1));
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

FILE: sv/prime_sieve_engine_top.sv
// prime_sieve_engine_top: one-bit prime flag store with sieve, trial-division
// classify and read operations; depends on pse_pkg and pse_mod_unit
//
// After reset the block runs a clearing pass over all MAX_NUMBER+1 flags, one flag
// per cycle, and accepts no transaction until it ends (configuration writes are
// taken throughout). Then one transaction is worked at a time through the
// flag memory, with one read and one write port, and a single bit-serial
// remainder unit. A sieve squares each base tried, reads its flag and, if it
// is set, clears its multiples up to the upper number one at a time. A classify
// reads, for each number, the flag of each trial base up to the trial limit and
// tests each flagged base with the remainder unit (16 remainder steps), stopping
// at the first divisor. The result is held in an output register so the next
// transaction may be accepted while it waits.
module prime_sieve_engine_top #(
  parameter int MAX_NUMBER = pse_pkg::MAX_NUMBER_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pse_pkg::OP_W-1:0]      operation,
  input  logic [pse_pkg::NUM_W-1:0]     lower_number,
  input  logic [pse_pkg::NUM_W-1:0]     upper_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          is_prime,
  output logic                          range_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pse_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pse_pkg::APB_W-1:0]     pwdata,
  output logic [pse_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);
  import pse_pkg::*;

  localparam int          Depth = MAX_NUMBER + 1;
  localparam int          AW    = $clog2(Depth);
  localparam int unsigned MaxN  = MAX_NUMBER;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_RD_WAIT,
    ST_SV_SQ,
    ST_SV_CHK,
    ST_SV_FLAG,
    ST_SV_MARK,
    ST_CL_RDQ,
    ST_CL_FLAG,
    ST_CL_DIV,
    ST_DONE
  } state_t;

  state_t state;

  logic [TRIAL_W-1:0] trial_limit;
  logic [AW-1:0]      clr_addr;
  logic [OP_W-1:0]    op_r;
  logic [NUM_W-1:0]   lo_r;
  logic [NUM_W-1:0]   hi_r;
  logic [NUM_W-1:0]   i_r;
  logic [2*NUM_W-1:0] sq_r;
  logic [NUM_W:0]     j_r;
  logic [NUM_W-1:0]   n_r;
  logic [TRIAL_W-1:0] q_r;
  logic               res_prime;
  logic               res_err;

  logic          mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic accept;
  logic start_err;
  logic q_ok;
  logic q_last;
  logic n_last;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    unique case (op_r)
      OP_SIEVE, OP_CLASSIFY: start_err = (lo_r > hi_r) || (32'(hi_r) > MaxN);
      OP_READ:               start_err = (32'(lo_r) > MaxN);
      default:               start_err = 1'b1;
    endcase
  end

  // a trial base past the store counts as unflagged
  assign q_ok   = (32'(q_r) <= MaxN);
  assign q_last = (q_r == trial_limit);
  assign n_last = (n_r == hi_r);

  assign mod_req.start    = (state == ST_CL_FLAG) && mem_rdata && q_ok;
  assign mod_req.dividend = n_r;
  assign mod_req.divisor  = q_r;

  pse_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // flag memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    mem_raddr = AW'(lo_r);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (clr_addr >= AW'(MIN_BASE));
      end
      ST_SV_CHK: mem_raddr = AW'(i_r);
      ST_SV_MARK: begin
        mem_we    = (j_r <= {1'b0, hi_r});
        mem_waddr = AW'(j_r);
      end
      ST_CL_RDQ: mem_raddr = AW'(q_r);
      ST_CL_DIV: begin
        mem_we    = mod_rsp.done && (mod_rsp.rem == '0);
        mem_waddr = AW'(n_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // the done state loads the next result itself
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_NUMBER)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r      <= operation;
            lo_r      <= lower_number;
            hi_r      <= upper_number;
            res_prime <= 1'b0;
            res_err   <= 1'b0;
            state     <= ST_START;
          end
        end
        ST_START: begin
          if (start_err) begin
            res_err <= 1'b1;
            state   <= ST_DONE;
          end else if (op_r == OP_READ) begin
            state <= ST_RD_WAIT;
          end else if (op_r == OP_SIEVE) begin
            i_r   <= (lo_r < NUM_W'(MIN_BASE)) ? NUM_W'(MIN_BASE) : lo_r;
            state <= ST_SV_SQ;
          end else if (trial_limit < TRIAL_W'(MIN_BASE)) begin
            state <= ST_DONE;
          end else begin
            n_r   <= lo_r;
            q_r   <= TRIAL_W'(MIN_BASE);
            state <= ST_CL_RDQ;
          end
        end
        ST_RD_WAIT: begin
          res_prime <= mem_rdata;
          state     <= ST_DONE;
        end
        ST_SV_SQ: begin
          sq_r  <= (2*NUM_W)'(i_r) * (2*NUM_W)'(i_r);
          state <= ST_SV_CHK;
        end
        ST_SV_CHK: begin
          if (sq_r > (2*NUM_W)'(hi_r)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_SV_FLAG;
          end
        end
        ST_SV_FLAG: begin
          if (mem_rdata) begin
            j_r   <= sq_r[NUM_W:0];
            state <= ST_SV_MARK;
          end else begin
            i_r   <= i_r + NUM_W'(1);
            state <= ST_SV_SQ;
          end
        end
        ST_SV_MARK: begin
          if (j_r <= {1'b0, hi_r}) begin
            j_r <= j_r + {1'b0, i_r};
          end else begin
            i_r   <= i_r + NUM_W'(1);
            state <= ST_SV_SQ;
          end
        end
        ST_CL_RDQ: begin
          state <= ST_CL_FLAG;
        end
        ST_CL_FLAG: begin
          if (mem_rdata && q_ok) begin
            state <= ST_CL_DIV;
          end else if (!q_last) begin
            q_r   <= q_r + TRIAL_W'(1);
            state <= ST_CL_RDQ;
          end else if (!n_last) begin
            n_r   <= n_r + NUM_W'(1);
            q_r   <= TRIAL_W'(MIN_BASE);
            state <= ST_CL_RDQ;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_CL_DIV: begin
          if (mod_rsp.done) begin
            // first divisor found ends the search for this number
            if (mod_rsp.rem != '0 && !q_last) begin
              q_r   <= q_r + TRIAL_W'(1);
              state <= ST_CL_RDQ;
            end else if (!n_last) begin
              n_r   <= n_r + NUM_W'(1);
              q_r   <= TRIAL_W'(MIN_BASE);
              state <= ST_CL_RDQ;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            is_prime    <= res_prime;
            range_error <= res_err;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // configuration register, single entry
  always_ff @(posedge clk) begin
    if (rst) begin
      trial_limit <= TRIAL_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == TRIAL_LIMIT_ADDR) begin
      trial_limit <= pwdata[TRIAL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {(APB_W-TRIAL_W)'(0), trial_limit};

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_START)
    else $error("accepted transaction did not enter start state");

  a_only_clears: assert property (@(posedge clk) disable iff (rst)
    mem_we && state != ST_CLEAR |-> !mem_wdata)
    else $error("flag set outside the clearing pass");

  a_mod_done_in_div: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == ST_CL_DIV)
    else $error("remainder result arrived outside divide wait");
`endif

endmodule
